// File: hdl/lpp_pkg.sv
// ----------------------------------------------------------------------------
// lpp_pkg - shared types and constants for the line page packer
// Page word layout, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lpp_pkg;

  localparam int unsigned MAX_LINES_DEF = 65536;

  // register indexes of the configuration port
  localparam int unsigned CFG_INDEX_W       = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_PAGE = 2'd1;

  localparam logic [7:0] ROWS_PER_PAGE_RESET = 8'd24;

  // output queue depth, room for two pages of one line plus slack
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [15:0] first;
    logic [16:0] end_index;
    logic [15:0] rows;
    logic        final_page;
    logic        last_of_item;
  } page_t;

  // what one line produces: a page closed on capacity before the line,
  // a page closed on break or last line after it, and the new open state
  typedef struct packed {
    logic        cap_valid;
    page_t       cap_page;
    logic        close_valid;
    page_t       close_page;
    logic [16:0] line_index_next;
    logic [15:0] open_first_next;
    logic [15:0] open_rows_next;
  } step_t;

endpackage

`default_nettype wire

// File: hdl/line_page_packer.sv
// ----------------------------------------------------------------------------
// line_page_packer - next-fit pagination of a stream of text lines
// Packs lines into pages by row capacity or forced breaks and emits one
// page word per closed page.
// ----------------------------------------------------------------------------
// Page words enter the page queue when their line word is accepted; the queue head drives the output ports.
// Throughput: one line word per cycle while line_stall is low; a line that closes two
//   pages pushes two page words, and the 4-entry page queue absorbs the difference.
// line_stall rises while fewer than two queue entries are free.
// Reset (rst, synchronous): clears the open page, line counter and queue;
//   scroll_mode returns to 0, rows_per_page to 24.
`default_nettype none

module line_page_packer #(
  parameter int unsigned MAX_LINES = lpp_pkg::MAX_LINES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [7:0]                      cfg_data,
  // line words
  input  wire logic                            line_valid,
  output logic                                 line_stall,
  input  wire logic [7:0]                      line_rows,
  input  wire logic                            break_after,
  input  wire logic                            last_line,
  // page words
  output logic                                 page_valid,
  input  wire logic                            page_stall,
  output logic [15:0]                          page_first,
  output logic [16:0]                          page_end,
  output logic [15:0]                          page_rows,
  output logic                                 final_page,
  output logic                                 last_of_item
);

  localparam int unsigned PTR_W = $clog2(lpp_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = PTR_W + 1;
  localparam logic [CNT_W-1:0] STALL_LEVEL = CNT_W'(lpp_pkg::QUEUE_DEPTH - 2);

  // configuration registers
  logic       scroll_mode;
  logic [7:0] rows_per_page;

  // open page state
  logic [16:0] line_index;
  logic [15:0] open_first;
  logic [15:0] open_rows;

  // page queue
  lpp_pkg::page_t queue [lpp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [PTR_W-1:0] wr_ptr_next;

  lpp_pkg::step_t step;
  lpp_pkg::page_t head;
  logic           line_acc;
  logic           page_acc;
  logic [1:0]     push_n;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_mode   <= 1'b0;
      rows_per_page <= lpp_pkg::ROWS_PER_PAGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpp_pkg::REG_SCROLL_MODE:   scroll_mode   <= cfg_data[0];
        lpp_pkg::REG_ROWS_PER_PAGE: rows_per_page <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  lpp_step #(
    .MAX_LINES(MAX_LINES)
  ) u_step (
    .line_index   (line_index),
    .open_first   (open_first),
    .open_rows    (open_rows),
    .scroll_mode  (scroll_mode),
    .rows_per_page(rows_per_page),
    .line_rows    (line_rows),
    .break_after  (break_after),
    .last_line    (last_line),
    .step         (step)
  );

  // stall is a function of queue fill only, so a line can always push two pages
  assign line_stall = (count > STALL_LEVEL);
  assign line_acc   = line_valid && !line_stall;
  assign page_valid = (count != '0);
  assign page_acc   = page_valid && !page_stall;
  assign push_n     = line_acc ? ({1'b0, step.cap_valid} + {1'b0, step.close_valid}) : 2'd0;

  always_comb begin
    count_next  = count + CNT_W'(push_n) - CNT_W'(page_acc);
    wr_ptr_next = wr_ptr + PTR_W'(push_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_index <= '0;
      open_first <= '0;
      open_rows  <= '0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      if (line_acc) begin
        line_index <= step.line_index_next;
        open_first <= step.open_first_next;
        open_rows  <= step.open_rows_next;
      end
      wr_ptr <= wr_ptr_next;
      if (page_acc) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

  // capacity page goes first, the break/last page right behind it
  always_ff @(posedge clk) begin
    if (line_acc) begin
      if (step.cap_valid) begin
        queue[wr_ptr] <= step.cap_page;
        if (step.close_valid) begin
          queue[wr_ptr + PTR_W'(1)] <= step.close_page;
        end
      end else if (step.close_valid) begin
        queue[wr_ptr] <= step.close_page;
      end
    end
  end

  assign head         = queue[rd_ptr];
  assign page_first   = head.first;
  assign page_end     = head.end_index;
  assign page_rows    = head.rows;
  assign final_page   = head.final_page;
  assign last_of_item = head.last_of_item;

endmodule

`default_nettype wire

// File: hdl/lpp_step.sv
// ----------------------------------------------------------------------------
// lpp_step - next-fit packing decision for one line
// Pure combinational: open page state and one line in, pages and next state out.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_step #(
  parameter int unsigned MAX_LINES = lpp_pkg::MAX_LINES_DEF
) (
  input  wire logic [16:0] line_index,
  input  wire logic [15:0] open_first,
  input  wire logic [15:0] open_rows,
  input  wire logic        scroll_mode,
  input  wire logic [7:0]  rows_per_page,
  input  wire logic [7:0]  line_rows,
  input  wire logic        break_after,
  input  wire logic        last_line,
  output lpp_pkg::step_t   step
);

  localparam logic [16:0] LAST_INDEX = 17'(MAX_LINES - 1);

  logic [7:0]  rows_eff;
  logic [7:0]  cap;
  logic        is_last;
  logic        closes;
  logic        nonempty;
  logic [16:0] fit_sum;
  logic        cap_split;
  logic [15:0] base_rows;
  logic [16:0] new_sum;
  logic [15:0] new_rows;
  logic [15:0] new_first;
  logic [16:0] index_inc;

  always_comb begin
    rows_eff  = (line_rows == 8'd0) ? 8'd1 : line_rows;
    cap       = (rows_per_page == 8'd0) ? 8'd1 : rows_per_page;
    is_last   = last_line || (line_index >= LAST_INDEX);
    closes    = break_after || is_last;
    nonempty  = (line_index != {1'b0, open_first});
    fit_sum   = {1'b0, open_rows} + {9'd0, rows_eff};
    cap_split = !scroll_mode && nonempty && (fit_sum > {9'd0, cap});

    base_rows = cap_split ? 16'd0 : open_rows;
    new_sum   = {1'b0, base_rows} + {9'd0, rows_eff};
    new_rows  = new_sum[16] ? 16'hFFFF : new_sum[15:0];
    new_first = cap_split ? line_index[15:0] : open_first;
    index_inc = line_index + 17'd1;

    step.cap_valid               = cap_split;
    step.cap_page.first          = open_first;
    step.cap_page.end_index      = line_index;
    step.cap_page.rows           = open_rows;
    step.cap_page.final_page     = 1'b0;
    step.cap_page.last_of_item   = !closes;

    step.close_valid             = closes;
    step.close_page.first        = new_first;
    step.close_page.end_index    = index_inc;
    step.close_page.rows         = new_rows;
    step.close_page.final_page   = is_last;
    step.close_page.last_of_item = 1'b1;

    if (is_last) begin
      step.line_index_next = 17'd0;
      step.open_first_next = 16'd0;
      step.open_rows_next  = 16'd0;
    end else if (break_after) begin
      step.line_index_next = index_inc;
      step.open_first_next = index_inc[15:0];
      step.open_rows_next  = 16'd0;
    end else begin
      step.line_index_next = index_inc;
      step.open_first_next = new_first;
      step.open_rows_next  = new_rows;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lpp_checker.sv
// ----------------------------------------------------------------------------
// lpp_checker - port-level checks for the line page packer
// Watches the page channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lpp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        page_valid,
  input wire logic        page_stall,
  input wire logic [15:0] page_first,
  input wire logic [16:0] page_end,
  input wire logic [15:0] page_rows,
  input wire logic        final_page,
  input wire logic        last_of_item
);

  // every page holds at least one line
  a_page_nonempty: assert property (@(posedge clk) disable iff (rst)
    page_valid |-> (page_end > {1'b0, page_first}))
    else $error("page word with no lines");

  // every page counts at least one row
  a_rows_nonzero: assert property (@(posedge clk) disable iff (rst)
    page_valid |-> (page_rows != 16'd0))
    else $error("page word with zero rows");

  // the document's final page is always the last page of its line
  a_final_is_last: assert property (@(posedge clk) disable iff (rst)
    (page_valid && final_page) |-> last_of_item)
    else $error("final page not marked last of its line");

  // queue is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !page_valid)
    else $error("page word valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (page_valid && page_stall) |=> (page_valid && $stable(page_first)
      && $stable(page_end) && $stable(page_rows)))
    else $error("stalled page word changed");

endmodule

bind line_page_packer lpp_checker u_lpp_checker (
  .clk         (clk),
  .rst         (rst),
  .page_valid  (page_valid),
  .page_stall  (page_stall),
  .page_first  (page_first),
  .page_end    (page_end),
  .page_rows   (page_rows),
  .final_page  (final_page),
  .last_of_item(last_of_item)
);

`default_nettype wire

// File: verif/line_page_checker.sv
// ----------------------------------------------------------------------------
// line_page_checker - page word predictor and comparator
// Watches the register, line and page channels of the line page packer.
// Each accepted line word is run through a software page packer, and each
// accepted page word is checked field by field against the oldest page owed.
// ----------------------------------------------------------------------------

module line_page_checker #(
  parameter int unsigned MAX_LINES = lpp_pkg::MAX_LINES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            line_valid,
  input  logic                            line_stall,
  input  logic [7:0]                      line_rows,
  input  logic                            break_after,
  input  logic                            last_line,
  input  logic                            page_valid,
  input  logic                            page_stall,
  input  logic [15:0]                     page_first,
  input  logic [16:0]                     page_end,
  input  logic [15:0]                     page_rows,
  input  logic                            final_page,
  input  logic                            last_of_item,
  output int                              fail_count,
  output int                              pages_due
);

  logic           scroll_on;
  logic [7:0]     page_cap;
  logic [16:0]    next_line;
  logic [15:0]    open_first;
  logic [15:0]    open_rows;
  lpp_pkg::page_t pages_owed[$];

  initial begin
    fail_count = 0;
    pages_due  = 0;
  end

  task automatic note_error(input string msg);
    fail_count++;
    if (fail_count <= 30) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  // next-fit packing of one line; queues the pages it closes
  task automatic pack_line(input logic [7:0] rows_in, input logic brk, input logic last_in);
    int unsigned    rows;
    int unsigned    cap;
    int unsigned    sum;
    logic           doc_end;
    lpp_pkg::page_t pg;
    rows    = (rows_in == 8'd0) ? 1 : rows_in;
    cap     = (page_cap == 8'd0) ? 1 : page_cap;
    doc_end = last_in || (next_line >= MAX_LINES - 1);
    // page full: close it before this line, unless the page is empty or scroll mode is on
    if (!scroll_on && next_line != {1'b0, open_first} && open_rows + rows > cap) begin
      pg.first        = open_first;
      pg.end_index    = next_line;
      pg.rows         = open_rows;
      pg.final_page   = 1'b0;
      pg.last_of_item = !(brk || doc_end);
      pages_owed      = {pages_owed, pg};
      open_first = next_line[15:0];
      open_rows  = '0;
    end
    sum       = open_rows + rows;
    open_rows = (sum > 32'h0000_FFFF) ? 16'hFFFF : sum[15:0];
    next_line = next_line + 17'd1;
    if (brk || doc_end) begin
      pg.first        = open_first;
      pg.end_index    = next_line;
      pg.rows         = open_rows;
      pg.final_page   = doc_end;
      pg.last_of_item = 1'b1;
      pages_owed      = {pages_owed, pg};
      if (doc_end) begin
        next_line  = '0;
        open_first = '0;
      end else begin
        open_first = next_line[15:0];
      end
      open_rows = '0;
    end
  endtask

  task automatic check_page();
    lpp_pkg::page_t want;
    if (pages_owed.size() == 0) begin
      note_error($sformatf("page word first=%0d end=%0d with no page owed",
                           page_first, page_end));
      return;
    end
    want = pages_owed.pop_front();
    if (page_first !== want.first)
      note_error($sformatf("page_first %0d, want %0d", page_first, want.first));
    if (page_end !== want.end_index)
      note_error($sformatf("page_end %0d, want %0d", page_end, want.end_index));
    if (page_rows !== want.rows)
      note_error($sformatf("page_rows %0d, want %0d (first %0d)",
                           page_rows, want.rows, want.first));
    if (final_page !== want.final_page)
      note_error($sformatf("final_page %b, want %b (first %0d)",
                           final_page, want.final_page, want.first));
    if (last_of_item !== want.last_of_item)
      note_error($sformatf("last_of_item %b, want %b (first %0d)",
                           last_of_item, want.last_of_item, want.first));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pages_owed.delete();
      scroll_on  = 1'b0;
      page_cap   = lpp_pkg::ROWS_PER_PAGE_RESET;
      next_line  = '0;
      open_first = '0;
      open_rows  = '0;
    end else begin
      // outgoing word first: it always belongs to an older line
      if (page_valid && !page_stall) check_page();
      if (line_valid && !line_stall) pack_line(line_rows, break_after, last_line);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lpp_pkg::REG_SCROLL_MODE) begin
          scroll_on = cfg_data[0];
        end else if (cfg_index == lpp_pkg::REG_ROWS_PER_PAGE) begin
          page_cap = cfg_data;
        end
      end
    end
    pages_due = pages_owed.size();
  end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench - regression for the line page packer
// Drives line words and register writes, stalls the page side at random and
// leaves prediction and comparison to line_page_checker. Covers directed
// corner cases, random documents under three idle mixes and a long receiver
// hold-off.
// ----------------------------------------------------------------------------

module testbench;

  // indexes with no register behind them; writes must be dropped
  localparam logic [lpp_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [lpp_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int HOLD_CYCLES = 300;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [lpp_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [7:0]                      cfg_data     = '0;
  logic                            line_valid   = 1'b0;
  logic                            line_stall;
  logic [7:0]                      line_rows    = '0;
  logic                            break_after  = 1'b0;
  logic                            last_line    = 1'b0;
  logic                            page_valid;
  logic                            page_stall   = 1'b0;
  logic [15:0]                     page_first;
  logic [16:0]                     page_end;
  logic [15:0]                     page_rows;
  logic                            final_page;
  logic                            last_of_item;

  int fail_count;
  int pages_due;

  // idle odds per cycle, in percent, for each side
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // stimulus asks for a long page-side hold-off; the receiver counts it
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  // capacity last written, only used to shape line heights
  int cap_hint      = int'(lpp_pkg::ROWS_PER_PAGE_RESET);

  always #5 clk = ~clk;

  line_page_packer #(.MAX_LINES(lpp_pkg::MAX_LINES_DEF)) DUT (.*);

  line_page_checker #(.MAX_LINES(lpp_pkg::MAX_LINES_DEF)) page_watch (.*);

  // page side: random stall, or a solid stretch on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      page_stall <= 1'b1;
    end else begin
      page_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one line word and return at the edge that takes it. Valid stays
  // high afterwards; the next call or settle() decides what follows.
  task automatic send_line(input logic [7:0] rows, input logic brk, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      line_valid <= 1'b0;
      @(posedge clk);
    end
    line_valid  <= 1'b1;
    line_rows   <= rows;
    break_after <= brk;
    last_line   <= last;
    @(posedge clk);
    while (line_stall) @(posedge clk);
  endtask

  // register write; lowers valid and idles before returning, so valid is
  // never lowered and raised in the same step
  task automatic write_reg(input logic [lpp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == lpp_pkg::REG_ROWS_PER_PAGE) cap_hint = int'(data);
    @(posedge clk);
  endtask

  // stop sending and wait for every owed page word, then idle before returning
  task automatic settle();
    line_valid <= 1'b0;
    @(posedge clk);
    while (pages_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic shuffle_config();
    logic [7:0] cap;
    case ($urandom_range(4))
      0:       cap = 8'd0;
      1:       cap = 8'd1;
      2:       cap = 8'd255;
      default: cap = 8'($urandom_range(2, 64));
    endcase
    write_reg(lpp_pkg::REG_ROWS_PER_PAGE, cap);
    // upper bits are don't-care; scroll mode about one time in four
    write_reg(lpp_pkg::REG_SCROLL_MODE, {7'($urandom_range(127)), $urandom_range(3) == 0});
    if ($urandom_range(3) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, 8'($urandom));
    end
  endtask

  // mostly heights no larger than the capacity so pages fill in a few lines
  function automatic logic [7:0] pick_rows();
    case ($urandom_range(7))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'($urandom_range(255));
      3:       return 8'($urandom_range(cap_hint));
      default: return 8'($urandom_range(0, cap_hint / 2 + 1));
    endcase
  endfunction

  // Whole documents, each closed by a last line. Some are noise: full-range
  // heights and frequent breaks. Now and then the block is drained and the
  // registers change, sometimes in the middle of a document.
  task automatic run_docs(input int line_count);
    int sent;
    int doc_len;
    int brk_pct;
    bit noisy;
    sent = 0;
    while (sent < line_count) begin
      doc_len = ($urandom_range(7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
      noisy   = ($urandom_range(7) == 0);
      brk_pct = noisy ? 50 : 8;
      for (int i = 0; i < doc_len; i++) begin
        send_line(noisy ? 8'($urandom_range(255)) : pick_rows(),
                  $urandom_range(99) < brk_pct, i == doc_len - 1);
        sent++;
        if ($urandom_range(47) == 0) begin
          settle();
          shuffle_config();
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 23;
    recv_idle_pct = 64;

    // Directed lines at reset config: paged, capacity 24.
    send_line(8'd0, 1'b0, 1'b0);    // zero height counts as one row
    send_line(8'd255, 1'b0, 1'b0);  // overflows: closes page, then taken alone
    send_line(8'd23, 1'b1, 1'b0);   // capacity close plus break close
    send_line(8'd10, 1'b0, 1'b0);
    send_line(8'd14, 1'b0, 1'b0);   // fills the page exactly, no split
    send_line(8'd1, 1'b0, 1'b0);    // one over: splits
    send_line(8'd5, 1'b1, 1'b1);    // break on the last line closes once
    send_line(8'd24, 1'b0, 1'b1);   // single-line document
    settle();

    // capacity zero acts as one row: every line opens a page
    write_reg(lpp_pkg::REG_ROWS_PER_PAGE, 8'd0);
    send_line(8'd0, 1'b0, 1'b0);
    send_line(8'd1, 1'b0, 1'b0);
    send_line(8'd2, 1'b1, 1'b0);
    send_line(8'd0, 1'b0, 1'b1);
    settle();

    // scroll mode, widest capacity, writes to unmapped indexes dropped
    write_reg(lpp_pkg::REG_SCROLL_MODE, 8'd1);
    write_reg(lpp_pkg::REG_ROWS_PER_PAGE, 8'd255);
    write_reg(REG_SPARE_LO, 8'hFF);
    write_reg(REG_SPARE_HI, 8'h00);
    send_line(8'd255, 1'b0, 1'b0);
    send_line(8'd255, 1'b1, 1'b0);
    send_line(8'd128, 1'b0, 1'b0);
    send_line(8'd0, 1'b0, 1'b0);
    settle();
    // back to paged mode mid-document (bit 0 clear, upper bits set)
    write_reg(lpp_pkg::REG_SCROLL_MODE, 8'hFE);
    send_line(8'd255, 1'b0, 1'b0);  // closes the scroll-built page
    send_line(8'd7, 1'b0, 1'b1);    // capacity close and final close
    settle();

    // Sender mostly busy, receiver mostly stalled, with one long hold-off
    // while lines keep coming so the page queue fills and stalls input.
    shuffle_config();
    hold_req = 1'b1;
    run_docs(220);
    settle();

    // The other way round, with a full drain partway through.
    send_idle_pct = 64;
    recv_idle_pct = 23;
    shuffle_config();
    run_docs(110);
    settle();
    run_docs(110);
    settle();

    // No idling on either side.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_config();
    run_docs(220);
    settle();

    // back to paged mode: a short run of documents from line zero
    write_reg(lpp_pkg::REG_SCROLL_MODE, 8'd0);
    run_docs(20);
    settle();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pages_due == 0) begin
      $display("line_page_packer regression: pass");
    end else begin
      $display("line_page_packer regression: fail");
    end
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #20_000_000;
    $display("line_page_packer regression: fail");
    $finish;
  end

endmodule

// File: line_page_packer.f
hdl/lpp_pkg.sv
hdl/lpp_step.sv
hdl/line_page_packer.sv
hdl/lpp_checker.sv
verif/line_page_checker.sv
verif/testbench.sv
